FILE: design/fsd_pkg.sv
// fsd_pkg: shared constants, types and codes of the error-diffusion dither
`default_nettype none

package fsd_pkg;

  // number formats
  localparam int FRAC_BITS  = 16;
  localparam int NUM_CH     = 4;
  localparam int MAX_WIDTH  = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = COL_W + 1;
  localparam int ROW_W      = 16;
  localparam int MODE_W     = 2;
  localparam int LEVEL_W    = 16;
  localparam int RECIP_W    = 25;
  localparam int RECIP_FRAC = 24;
  localparam int SAMPLE_W   = 18;
  localparam int CLIP_W     = FRAC_BITS + 1;
  localparam int OUT_W      = 17;
  localparam int BUF_W      = FRAC_BITS + 4;
  localparam int VAL_W      = 36;
  localparam int ACC_W      = 40;
  localparam int RECON_W    = LEVEL_W + RECIP_W + 1 - (RECIP_FRAC - FRAC_BITS);

  // stream and config port widths
  localparam int IN_DATA_W  = ((NUM_CH * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((NUM_CH * OUT_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RECIP_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DITHER_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RECIP   = 3'd4;

  // mode codes: bit 1 set selects gray
  localparam logic [MODE_W-1:0] MODE_CLIP    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHANNEL = 2'd1;

  // reset values
  localparam logic [WIDTH_W-1:0] RST_WIDTH  = WIDTH_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0]   RST_HEIGHT = ROW_W'(1);
  localparam logic [LEVEL_W-1:0] RST_LEVELS = LEVEL_W'(255);
  localparam logic [RECIP_W-1:0] RST_RECIP  = RECIP_W'(65793);

  // gray weights in hundredths
  localparam int GRAY_WT_R    = 30;
  localparam int GRAY_WT_G    = 59;
  localparam int GRAY_WT_B    = 11;
  localparam int GRAY_DIV     = 100;
  localparam int GRAY_RND     = GRAY_DIV / 2;
  localparam int GRAY_SUM_MAX = GRAY_DIV * (1 << FRAC_BITS);
  localparam int GDIV_IN_W    = $clog2(GRAY_SUM_MAX + 1);
  localparam int DIV100_SH    = 30;
  localparam int DIV100_MUL   = ((1 << DIV100_SH) + GRAY_DIV - 1) / GRAY_DIV;
  localparam int DIV100_MUL_W = $clog2(DIV100_MUL + 1);

  // strobes from the sequencer to a quantiser lane
  typedef struct packed {
    logic lvl_en;
    logic rec_en;
  } fsd_lane_ctrl_t;

endpackage

`default_nettype wire

FILE: design/fsd_quant.sv
// fsd_quant: one channel lane, level index then reconstructed level value
`default_nettype none

module fsd_quant
  import fsd_pkg::*;
(
  input  logic                 clk,
  input  fsd_lane_ctrl_t       ctrl,
  input  logic [CLIP_W-1:0]    level_in,
  input  logic [LEVEL_W-1:0]   levels,
  input  logic [RECIP_W-1:0]   step_recip,
  output logic [LEVEL_W-1:0]   level_idx,
  output logic [RECON_W-1:0]   level_val
);

  localparam int PROD_W  = CLIP_W + LEVEL_W;
  localparam int IDX_W   = PROD_W + 1 - FRAC_BITS;
  localparam int REC_SH  = RECIP_FRAC - FRAC_BITS;
  localparam int RPROD_W = LEVEL_W + RECIP_W + 1;

  // ceil(x*f - 1/2) == floor((x*f + one/2 - 1) / one)
  localparam logic [PROD_W:0]    IDX_RND = (PROD_W + 1)'((1 << (FRAC_BITS - 1)) - 1);
  localparam logic [RPROD_W-1:0] REC_RND = RPROD_W'(1 << (REC_SH - 1));

  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    scaled;
  logic [IDX_W-1:0]   idx_raw;
  logic [LEVEL_W-1:0] idx_sat;
  logic [RPROD_W-1:0] recon;

  always_comb begin
    prod    = PROD_W'(level_in) * PROD_W'(levels);
    scaled  = {1'b0, prod} + IDX_RND;
    idx_raw = scaled[PROD_W:FRAC_BITS];
    idx_sat = (idx_raw > IDX_W'(levels)) ? levels : idx_raw[LEVEL_W-1:0];
    recon   = RPROD_W'(level_idx) * RPROD_W'(step_recip) + REC_RND;
  end

  always_ff @(posedge clk) begin
    if (ctrl.lvl_en) begin
      level_idx <= idx_sat;
    end
    if (ctrl.rec_en) begin
      level_val <= recon[RPROD_W-1:REC_SH];
    end
  end

endmodule

`default_nettype wire

FILE: design/floyd_steinberg_dither.sv
// floyd_steinberg_dither: top level, error-diffusion dither of an rgba pixel stream
//
// usage
//   pixels enter in raster order on the s_ stream, one item per pixel, four
//   signed q2.16 samples in s_tdata and the per-channel nan flags in s_tuser
//   one result item per pixel leaves on the m_ stream: four level indices
//   (clipped q1.16 values in clip-only mode), m_tlast high on the image's last pixel
//   configuration must be written through cfg_wr_en / cfg_index / cfg_wr_data while idle;
//   the block itself does not enforce this
// sequence
//   per-channel mode: accept and clip, carry add, the registered level multiply, the
//   registered reconstruction multiply, error subtract, then commit into the output register
//   gray mode adds the gray sum and the reciprocal divide by 100 before the level multiply
//   clip-only mode: accept and clip, then commit; no pixel is taken before the last is done
//   a tail step follows the commit of a row's last pixel that diffuses downward: the
//   row error memory has one write port and that pixel writes two entries
// reset and stall
//   rst (synchronous) clears the position, the carries and the output valid; the
//   row error memory is not cleared, row 0 never reads it
//   a new pixel is taken while a result still waits; a pixel whose result cannot
//   be placed holds in the commit step until m_tready frees the output register
`default_nettype none

module floyd_steinberg_dither
  import fsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // slave stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // red_sample, green_sample, blue_sample, alpha_sample
  input  logic [NUM_CH-1:0]     s_tuser,   // nan_mask
  // master stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // red_out, green_out, blue_out, alpha_out, zero pad
  output logic                  m_tlast,   // frame_end
  // configuration writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int DIFF_SH  = 4;
  localparam int GSUM_W   = VAL_W + 8;
  localparam int GPROD_W  = GDIV_IN_W + DIV100_MUL_W;
  localparam int MEM_W    = NUM_CH * BUF_W;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_ONE = SAMPLE_W'(1 << FRAC_BITS);
  localparam logic [CLIP_W-1:0]          CLIP_ONE   = CLIP_W'(1 << FRAC_BITS);
  localparam logic [CLIP_W-1:0]          CLIP_HALF  = CLIP_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [VAL_W-1:0]    VAL_ONE    = VAL_W'(1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0]    CARRY_RND  = ACC_W'(1 << (DIFF_SH - 1));
  localparam logic signed [ACC_W-1:0]    BUF_MAX    = ACC_W'((1 << (BUF_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0]    BUF_MIN    = ACC_W'(-(1 << (BUF_W - 1)));
  localparam logic signed [GSUM_W-1:0]   GSUM_MAX_S = GSUM_W'(GRAY_SUM_MAX);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VAL,
    ST_GSUM,
    ST_GDIV,
    ST_LVL,
    ST_REC,
    ST_ERR,
    ST_COMMIT,
    ST_TAIL
  } state_t;

  function automatic logic [BUF_W-1:0] sat_buf(input logic signed [ACC_W-1:0] x);
    if (x > BUF_MAX) begin
      return BUF_MAX[BUF_W-1:0];
    end else if (x < BUF_MIN) begin
      return BUF_MIN[BUF_W-1:0];
    end
    return x[BUF_W-1:0];
  endfunction

  // configuration registers
  logic [WIDTH_W-1:0] cfg_width;
  logic [ROW_W-1:0]   cfg_height;
  logic [MODE_W-1:0]  cfg_mode;
  logic [LEVEL_W-1:0] cfg_levels;
  logic [RECIP_W-1:0] cfg_recip;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= RST_WIDTH;
      cfg_height <= RST_HEIGHT;
      cfg_mode   <= MODE_CHANNEL;
      cfg_levels <= RST_LEVELS;
      cfg_recip  <= RST_RECIP;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_width  <= cfg_wr_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height <= cfg_wr_data[ROW_W-1:0];
        REG_DITHER_MODE:  cfg_mode   <= cfg_wr_data[MODE_W-1:0];
        REG_LEVELS:       cfg_levels <= cfg_wr_data[LEVEL_W-1:0];
        REG_STEP_RECIP:   cfg_recip  <= cfg_wr_data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  state_t                   state;
  logic [COL_W-1:0]         col_cnt;
  logic [ROW_W-1:0]         row_cnt;
  logic [COL_W-1:0]         col_r;
  logic [ROW_W-1:0]         row_r;
  logic                     last_col_r;
  logic                     last_row_r;
  logic                     diffuse_r;
  logic                     bypass_r;
  logic                     gray_mode_r;
  logic [CLIP_W-1:0]        clip_v    [NUM_CH];
  logic signed [VAL_W-1:0]  val_r     [NUM_CH];
  logic signed [VAL_W-1:0]  err_r     [NUM_CH];
  logic signed [ACC_W-1:0]  carry     [NUM_CH];
  logic signed [ACC_W-1:0]  pend_prev [NUM_CH];
  logic signed [VAL_W-1:0]  pend_cur  [NUM_CH];
  logic [GDIV_IN_W-1:0]     gsum_r;
  logic [CLIP_W-1:0]        gray_val;
  logic [MEM_W-1:0]         tail_data_r;

  // row error memory, one entry per column, four channels side by side
  logic [MEM_W-1:0] row_mem [MAX_WIDTH];
  logic [MEM_W-1:0] mem_rd;
  logic             mem_we;
  logic [COL_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata;

  // effective geometry of the current pixel
  logic [WIDTH_W-1:0] width_eff;
  logic [ROW_W-1:0]   height_eff;
  logic [COL_W-1:0]   col_cur;
  logic [ROW_W-1:0]   row_cur;
  logic               last_col_cur;
  logic               last_row_cur;
  logic               diffuse_cur;

  always_comb begin
    if (cfg_width == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (cfg_width > WIDTH_W'(MAX_WIDTH)) begin
      width_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_eff = cfg_width;
    end
    height_eff = (cfg_height == '0) ? ROW_W'(1) : cfg_height;
    // a position past a shrunk image counts as the last column or row
    col_cur = (WIDTH_W'(col_cnt) >= width_eff) ? COL_W'(width_eff - WIDTH_W'(1)) : col_cnt;
    row_cur = (row_cnt >= height_eff) ? height_eff - ROW_W'(1) : row_cnt;
    last_col_cur = (WIDTH_W'(col_cur) == width_eff - WIDTH_W'(1));
    last_row_cur = (row_cur == height_eff - ROW_W'(1));
    diffuse_cur  = (width_eff >= WIDTH_W'(3)) && (height_eff >= ROW_W'(3)) &&
                   (cfg_mode != MODE_CLIP);
  end

  // input clip, nan reads as one half
  logic signed [SAMPLE_W-1:0] sample    [NUM_CH];
  logic [CLIP_W-1:0]          clip_next [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sample[c] = signed'(s_tdata[c*SAMPLE_W +: SAMPLE_W]);
      if (s_tuser[c]) begin
        clip_next[c] = CLIP_HALF;
      end else if (sample[c] <= 0) begin
        clip_next[c] = '0;
      end else if (sample[c] >= SAMPLE_ONE) begin
        clip_next[c] = CLIP_ONE;
      end else begin
        clip_next[c] = sample[c][CLIP_W-1:0];
      end
    end
  end

  // diffused error added to the clipped value
  logic signed [BUF_W-1:0] incoming  [NUM_CH];
  logic signed [ACC_W-1:0] carry_sum [NUM_CH];
  logic signed [VAL_W-1:0] clip_ext  [NUM_CH];
  logic signed [VAL_W-1:0] val_next  [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      incoming[c]  = (row_r != '0) ? mem_rd[c*BUF_W +: BUF_W] : '0;
      carry_sum[c] = carry[c] + ACC_W'(incoming[c]) + CARRY_RND;
      clip_ext[c]  = signed'(VAL_W'(clip_v[c]));
      val_next[c]  = diffuse_r ? clip_ext[c] + VAL_W'(carry_sum[c] >>> DIFF_SH) : clip_ext[c];
    end
  end

  // gray: weighted sum clamped to the range that can change the level, then / 100
  logic signed [GSUM_W-1:0] gray_sum;
  logic [GDIV_IN_W-1:0]     gray_clamped;
  logic [GPROD_W-1:0]       gray_prod;

  always_comb begin
    gray_sum = GSUM_W'(val_r[0]) * GSUM_W'(GRAY_WT_R) +
               GSUM_W'(val_r[1]) * GSUM_W'(GRAY_WT_G) +
               GSUM_W'(val_r[2]) * GSUM_W'(GRAY_WT_B) + GSUM_W'(GRAY_RND);
    if (gray_sum < 0) begin
      gray_clamped = '0;
    end else if (gray_sum > GSUM_MAX_S) begin
      gray_clamped = GDIV_IN_W'(GRAY_SUM_MAX);
    end else begin
      gray_clamped = gray_sum[GDIV_IN_W-1:0];
    end
    gray_prod = GPROD_W'(gsum_r) * GPROD_W'(DIV100_MUL);
  end

  // quantiser lanes
  fsd_lane_ctrl_t          lane_ctrl;
  logic [CLIP_W-1:0]       level_in  [NUM_CH];
  logic [LEVEL_W-1:0]      level_idx [NUM_CH];
  logic [RECON_W-1:0]      level_val [NUM_CH];

  assign lane_ctrl.lvl_en = (state == ST_LVL);
  assign lane_ctrl.rec_en = (state == ST_REC);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      // values outside [0, 1] only ever saturate the index
      if (gray_mode_r) begin
        level_in[c] = gray_val;
      end else if (val_r[c] < 0) begin
        level_in[c] = '0;
      end else if (val_r[c] > VAL_ONE) begin
        level_in[c] = CLIP_ONE;
      end else begin
        level_in[c] = val_r[c][CLIP_W-1:0];
      end
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    fsd_quant u_quant (
      .clk        (clk),
      .ctrl       (lane_ctrl),
      .level_in   (level_in[c]),
      .levels     (cfg_levels),
      .step_recip (cfg_recip),
      .level_idx  (level_idx[c]),
      .level_val  (level_val[c])
    );
  end

  // quantisation error and its share-out
  logic signed [VAL_W-1:0] nv_ext     [NUM_CH];
  logic signed [ACC_W-1:0] err_ext    [NUM_CH];
  logic signed [ACC_W-1:0] err_x3     [NUM_CH];
  logic signed [ACC_W-1:0] err_x5     [NUM_CH];
  logic signed [ACC_W-1:0] err_x7     [NUM_CH];
  logic signed [ACC_W-1:0] prev_next  [NUM_CH];
  logic [MEM_W-1:0]        left_data;
  logic [MEM_W-1:0]        tail_data;
  logic [OUT_DATA_W-1:0]   out_pack;
  logic                    out_free;

  always_comb begin
    left_data = '0;
    tail_data = '0;
    out_pack  = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      nv_ext[c]    = signed'(VAL_W'(level_val[c]));
      err_ext[c]   = ACC_W'(err_r[c]);
      err_x3[c]    = (err_ext[c] <<< 1) + err_ext[c];
      err_x5[c]    = (err_ext[c] <<< 2) + err_ext[c];
      err_x7[c]    = (err_ext[c] <<< 3) - err_ext[c];
      prev_next[c] = ((col_r != '0) ? ACC_W'(pend_cur[c]) : '0) + err_x5[c];
      left_data[c*BUF_W +: BUF_W] = sat_buf(pend_prev[c] + err_x3[c]);
      tail_data[c*BUF_W +: BUF_W] = sat_buf(prev_next[c]);
      out_pack[c*OUT_W +: OUT_W]  = bypass_r ? clip_v[c] : OUT_W'(level_idx[c]);
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // memory write: lower-left entry at commit, the row's last entry in the tail state after it
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = col_r;
    mem_wdata = tail_data_r;
    if (state == ST_COMMIT && out_free && diffuse_r && !last_row_r && col_r != '0) begin
      mem_we    = 1'b1;
      mem_waddr = col_r - COL_W'(1);
      mem_wdata = left_data;
    end else if (state == ST_TAIL) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    mem_rd <= row_mem[col_cur];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      col_cnt  <= '0;
      row_cnt  <= '0;
      m_tvalid <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        carry[c]     <= '0;
        pend_prev[c] <= '0;
        pend_cur[c]  <= '0;
      end
    end else begin
      if (state == ST_COMMIT && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= out_pack;
        m_tlast  <= last_col_r && last_row_r;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            col_r       <= col_cur;
            row_r       <= row_cur;
            last_col_r  <= last_col_cur;
            last_row_r  <= last_row_cur;
            diffuse_r   <= diffuse_cur;
            bypass_r    <= (cfg_mode == MODE_CLIP);
            gray_mode_r <= cfg_mode[1];
            for (int c = 0; c < NUM_CH; c++) begin
              clip_v[c] <= clip_next[c];
            end
            state <= (cfg_mode == MODE_CLIP) ? ST_COMMIT : ST_VAL;
          end
        end
        ST_VAL: begin
          for (int c = 0; c < NUM_CH; c++) begin
            val_r[c] <= val_next[c];
          end
          state <= gray_mode_r ? ST_GSUM : ST_LVL;
        end
        ST_GSUM: begin
          gsum_r <= gray_clamped;
          state  <= ST_GDIV;
        end
        ST_GDIV: begin
          gray_val <= CLIP_W'(gray_prod >> DIV100_SH);
          state    <= ST_LVL;
        end
        ST_LVL: begin
          state <= ST_REC;
        end
        ST_REC: begin
          state <= ST_ERR;
        end
        ST_ERR: begin
          for (int c = 0; c < NUM_CH; c++) begin
            err_r[c] <= val_r[c] - nv_ext[c];
          end
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (out_free) begin
            for (int c = 0; c < NUM_CH; c++) begin
              if (!diffuse_r || last_col_r) begin
                carry[c] <= '0;
              end else begin
                carry[c] <= err_x7[c];
              end
              if (diffuse_r && !last_row_r) begin
                pend_prev[c] <= prev_next[c];
                pend_cur[c]  <= err_r[c];
              end
            end
            tail_data_r <= tail_data;
            if (last_col_r) begin
              col_cnt <= '0;
              row_cnt <= last_row_r ? '0 : row_r + ROW_W'(1);
            end else begin
              col_cnt <= col_r + COL_W'(1);
              row_cnt <= row_r;
            end
            state <= (diffuse_r && !last_row_r && last_col_r) ? ST_TAIL : ST_IDLE;
          end
        end
        ST_TAIL: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a commit always leaves a result in the output register
  a_commit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT && out_free) |=> m_tvalid)
    else $error("commit did not load the output register");

  // the second memory write only follows a last-column commit that diffuses
  a_tail_origin: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAIL) |-> ($past(state) == ST_COMMIT && last_col_r && diffuse_r))
    else $error("tail write without a diffusing last-column commit");

  // the row error memory is only written by pixels that diffuse downward
  a_mem_write_rule: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (diffuse_r && !last_row_r))
    else $error("row error memory written outside a diffusing row");

endmodule

`default_nettype wire
